// ===== rtl/core/lzce_pkg.sv =====
// Package: shared constants, codes and types of the Laplacian zero-crossing edge unit.
package lzce_pkg;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int THRESH_W   = 10;
    localparam int MODE_W     = 2;
    localparam int ROW_W      = 14;
    localparam int OROW_W     = 12;
    localparam int PIX_W      = 8;
    localparam int CLS_W      = 2;
    localparam int SUM_W      = 13;
    localparam int MAG_W      = 12;
    localparam int RECIP      = 2731;
    localparam int RECIP_W    = 12;
    localparam int RECIP_SH   = 13;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd512;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 13'd512;
    localparam logic [THRESH_W-1:0] RST_THRESH = 10'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd3;

    localparam logic [MODE_W-1:0] MODE_FOUR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EIGHT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MINVAR = 2'd2;

    localparam logic [CLS_W-1:0] CLS_NEG     = 2'd0;
    localparam logic [CLS_W-1:0] CLS_NEUTRAL = 2'd1;
    localparam logic [CLS_W-1:0] CLS_POS     = 2'd2;

    typedef struct packed {
        logic qv;
        logic qin;
        logic qtop;
        logic qleft;
        logic qright;
        logic ov;
        logic otop;
        logic obot;
        logic oleft;
        logic oright;
        logic last;
    } lzce_tag_t;

endpackage

// ===== rtl/core/laplacian_zero_crossing_edges_unit.sv =====
// Top level: stream ports, configuration, frame position tracking and output register.
//
// Takes one word per clock and gives one word per clock once the window has
// filled, unless m_tready stalls the output: grey pixels go in raster order, a
// drain word (tuser high) after the last pixel of a frame advances the pipeline,
// and a frame needs W*H pixels followed by 2*W+2 further words. Result words
// for the frame's pixels come out in raster order, tlast marking the final one.
// The steady rate is set by the two line memories, each read once and written
// once per cycle; results pass stages s1 to s4, c1, c2 and the output register.
// The line memories need no clearing after reset. Configuration writes restart
// the frame; the user must let them go in only while idle; the unit does not check.
module laplacian_zero_crossing_edges_unit #(
    parameter int MAX_WIDTH = lzce_pkg::DEF_MAX_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lzce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lzce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] pixel_value
    input  logic                             s_tuser,   // [0] is_drain
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [0] is_background, [7:1] zero
    output logic                             m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = lzce_pkg::ROW_W;
    localparam int OW = lzce_pkg::OROW_W;
    localparam int HW = lzce_pkg::HEIGHT_W;

    logic [lzce_pkg::WIDTH_W-1:0]  width_reg;
    logic [HW-1:0]                 height_reg;
    logic [lzce_pkg::THRESH_W-1:0] thresh_reg;
    logic [lzce_pkg::MODE_W-1:0]   mode_reg;

    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] o_col_reg, o_col_next;
    logic [OW-1:0] o_row_reg, o_row_next;

    logic          out_valid_reg, out_bg_reg, out_last_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] w_m1;
    logic [OW-1:0] h_m1;
    logic          adv, accept, take, pix_phase;
    logic [RW-1:0] qr;
    logic [CW-1:0] qc;
    logic [7:0]    pix;
    lzce_pkg::lzce_tag_t tag;

    logic                       pp_valid;
    logic [lzce_pkg::CLS_W-1:0] pp_class;
    logic [CW-1:0]              pp_qc;
    lzce_pkg::lzce_tag_t        pp_tag;
    logic                       cp_valid, cp_bg, cp_last;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (32'(height_reg) > 32'(lzce_pkg::MAX_HEIGHT))
        begin
            h_eff = HW'(lzce_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign w_m1 = CW'(w_eff - WW'(1));
    assign h_m1 = OW'(h_eff - HW'(1));

    assign adv       = !out_valid_reg || m_tready;
    assign s_tready  = adv;
    assign accept    = s_tvalid && adv;
    assign pix_phase = in_row_reg < RW'(h_eff);
    assign take      = accept && !(pix_phase && s_tuser);
    assign pix       = pix_phase ? s_tdata : 8'd0;

    // position of the pixel classed and of the pixel emitted by this word
    always_comb
    begin
        qr = (in_col_reg != '0) ? in_row_reg - RW'(1) : in_row_reg - RW'(2);
        qc = (in_col_reg != '0) ? in_col_reg - CW'(1) : w_m1;
        tag.qv     = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);
        tag.qin    = qr < RW'(h_eff);
        tag.qtop   = (qr == '0);
        tag.qleft  = (qc == '0);
        tag.qright = (qc == w_m1);
        tag.ov     = (in_row_reg >= RW'(4)) ||
                     (in_row_reg == RW'(3) && w_eff >= WW'(2)) ||
                     (in_row_reg == RW'(2) && in_col_reg >= CW'(2));
        tag.otop   = (o_row_reg == '0);
        tag.obot   = (o_row_reg == h_m1);
        tag.oleft  = (o_col_reg == '0);
        tag.oright = (o_col_reg == w_m1);
        tag.last   = tag.obot && tag.oright;
    end

    always_comb
    begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        o_col_next  = o_col_reg;
        o_row_next  = o_row_reg;
        if (cfg_we || (take && tag.ov && tag.last))
        begin
            in_col_next = '0;
            in_row_next = '0;
            o_col_next  = '0;
            o_row_next  = '0;
        end
        else if (take)
        begin
            if (in_col_reg == w_m1)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (tag.ov)
            begin
                if (o_col_reg == w_m1)
                begin
                    o_col_next = '0;
                    o_row_next = o_row_reg + OW'(1);
                end
                else
                begin
                    o_col_next = o_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lzce_pkg::RST_WIDTH;
            height_reg <= lzce_pkg::RST_HEIGHT;
            thresh_reg <= lzce_pkg::RST_THRESH;
            mode_reg   <= lzce_pkg::MODE_FOUR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lzce_pkg::CFG_WIDTH:  width_reg  <= cfg_data[lzce_pkg::WIDTH_W-1:0];
                lzce_pkg::CFG_HEIGHT: height_reg <= cfg_data[HW-1:0];
                lzce_pkg::CFG_THRESH: thresh_reg <= cfg_data[lzce_pkg::THRESH_W-1:0];
                lzce_pkg::CFG_MODE:   mode_reg   <= cfg_data[lzce_pkg::MODE_W-1:0];
                default:              mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            o_col_reg     <= '0;
            o_row_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            o_col_reg  <= o_col_next;
            o_row_reg  <= o_row_next;
            if (cfg_we)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                out_valid_reg <= cp_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_bg_reg   <= cp_bg;
            out_last_reg <= cp_last;
        end
    end

    lzce_pixel_path #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_pixel (
        .clk            (clk),
        .rst_n          (rst_n),
        .flush          (cfg_we),
        .adv            (adv),
        .in_valid       (take),
        .in_pix         (pix),
        .in_col         (in_col_reg),
        .in_qc          (qc),
        .in_tag         (tag),
        .kernel_mode    (mode_reg),
        .edge_threshold (thresh_reg),
        .out_valid      (pp_valid),
        .out_class      (pp_class),
        .out_qc         (pp_qc),
        .out_tag        (pp_tag)
    );

    lzce_class_path #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_class (
        .clk            (clk),
        .rst_n          (rst_n),
        .flush          (cfg_we),
        .adv            (adv),
        .in_valid       (pp_valid),
        .in_class       (pp_class),
        .in_col         (pp_qc),
        .in_tag         (pp_tag),
        .out_valid      (cp_valid),
        .out_background (cp_bg),
        .out_last       (cp_last)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_bg_reg};
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(in_col_reg) < w_eff)
        else $error("input column beyond row width");

    a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(o_col_reg) < w_eff && HW'(o_row_reg) < h_eff)
        else $error("output position outside frame");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (take && tag.ov && tag.last && !cfg_we) |=> (in_row_reg == '0 && o_row_reg == '0))
        else $error("frame did not restart after last output");
`endif

endmodule

// ===== rtl/core/lzce_pixel_path.sv =====
// Pixel line memory, 3x3 pixel window, kernel sum, divide by three and classing.
module lzce_pixel_path #(
    parameter int MAX_WIDTH = lzce_pkg::DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           flush,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic [lzce_pkg::PIX_W-1:0]     in_pix,
    input  logic [CW-1:0]                  in_col,
    input  logic [CW-1:0]                  in_qc,
    input  lzce_pkg::lzce_tag_t            in_tag,
    input  logic [lzce_pkg::MODE_W-1:0]    kernel_mode,
    input  logic [lzce_pkg::THRESH_W-1:0]  edge_threshold,
    output logic                           out_valid,
    output logic [lzce_pkg::CLS_W-1:0]     out_class,
    output logic [CW-1:0]                  out_qc,
    output lzce_pkg::lzce_tag_t            out_tag
);

    localparam int PW = lzce_pkg::PIX_W;
    localparam int SW = lzce_pkg::SUM_W;
    localparam int MW = lzce_pkg::MAG_W;

    logic [2*PW-1:0] mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_reg;

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [PW-1:0]       s1_pix_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [CW-1:0]       s1_qc_reg, s2_qc_reg, s3_qc_reg, s4_qc_reg;
    lzce_pkg::lzce_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    logic [PW-1:0]       win_reg [3][3];
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] quot_reg;
    logic signed [SW-1:0] quot_next;

    logic                wr_en;
    logic [2*PW-1:0]     wr_data;
    logic [PW-1:0]       px [3][3];
    logic signed [SW-1:0] cen, edg, cor;
    logic                mode_eight, mode_minvar;
    logic [MW-1:0]       mag;
    logic [MW+lzce_pkg::RECIP_W-1:0] prod;
    logic [MW-1:0]       qmag;
    logic signed [SW-1:0] thr;

    assign mode_eight  = (kernel_mode == lzce_pkg::MODE_EIGHT);
    assign mode_minvar = (kernel_mode == lzce_pkg::MODE_MINVAR);

    assign wr_en   = adv && s1_valid_reg;
    assign wr_data = {rd_reg[PW-1:0], s1_pix_reg};

    // line memory: low byte previous row, high byte the row before it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_col_reg] <= wr_data;
        end
        if (adv && in_valid)
        begin
            rd_reg <= (wr_en && s1_col_reg == in_col) ? wr_data : mem[in_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_reg[2*PW-1:PW];
            win_reg[1][2] <= rd_reg[PW-1:0];
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg <= in_pix;
            s1_col_reg <= in_col;
            s1_qc_reg  <= in_qc;
            s1_tag_reg <= in_tag;
            s2_qc_reg  <= s1_qc_reg;
            s2_tag_reg <= s1_tag_reg;
            s3_qc_reg  <= s2_qc_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_qc_reg  <= s3_qc_reg;
            s4_tag_reg <= s3_tag_reg;
            sum_reg    <= sum_next;
            quot_reg   <= quot_next;
        end
    end

    // zero padding outside the frame
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if ((r == 0 && s2_tag_reg.qtop) || (c == 0 && s2_tag_reg.qleft) ||
                    (c == 2 && s2_tag_reg.qright))
                begin
                    px[r][c] = '0;
                end
                else
                begin
                    px[r][c] = win_reg[r][c];
                end
            end
        end
        cen = SW'(px[1][1]);
        edg = SW'(px[0][1]) + SW'(px[1][0]) + SW'(px[1][2]) + SW'(px[2][1]);
        cor = SW'(px[0][0]) + SW'(px[0][2]) + SW'(px[2][0]) + SW'(px[2][2]);
        if (mode_eight)
        begin
            sum_next = edg + cor - (cen <<< 3);
        end
        else if (mode_minvar)
        begin
            sum_next = (cor <<< 1) - edg - (cen <<< 2);
        end
        else
        begin
            sum_next = edg - (cen <<< 2);
        end
    end

    // divide by three toward zero (not in four mode): reciprocal multiply on magnitude
    always_comb
    begin
        mag  = sum_reg[SW-1] ? MW'(-sum_reg) : MW'(sum_reg);
        prod = mag * lzce_pkg::RECIP_W'(lzce_pkg::RECIP);
        qmag = MW'(prod >> lzce_pkg::RECIP_SH);
        if (mode_eight || mode_minvar)
        begin
            quot_next = sum_reg[SW-1] ? -$signed(SW'(qmag)) : $signed(SW'(qmag));
        end
        else
        begin
            quot_next = sum_reg;
        end
    end

    always_comb
    begin
        thr = $signed(SW'(edge_threshold));
        if (!s4_tag_reg.qin)
        begin
            out_class = lzce_pkg::CLS_NEUTRAL;
        end
        else if (quot_reg >= thr)
        begin
            out_class = lzce_pkg::CLS_POS;
        end
        else if (quot_reg <= -thr)
        begin
            out_class = lzce_pkg::CLS_NEG;
        end
        else
        begin
            out_class = lzce_pkg::CLS_NEUTRAL;
        end
    end

    assign out_valid = s4_valid_reg && s4_tag_reg.qv;
    assign out_qc    = s4_qc_reg;
    assign out_tag   = s4_tag_reg;

endmodule

// ===== rtl/core/lzce_class_path.sv =====
// Class line memory, 3x3 class window and zero-crossing test.
module lzce_class_path #(
    parameter int MAX_WIDTH = lzce_pkg::DEF_MAX_WIDTH,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       flush,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [lzce_pkg::CLS_W-1:0] in_class,
    input  logic [CW-1:0]              in_col,
    input  lzce_pkg::lzce_tag_t        in_tag,
    output logic                       out_valid,
    output logic                       out_background,
    output logic                       out_last
);

    localparam int KW = lzce_pkg::CLS_W;

    logic [2*KW-1:0] mem [MAX_WIDTH];
    logic [2*KW-1:0] rd_reg;

    logic                c1_valid_reg, c2_valid_reg;
    logic [KW-1:0]       c1_class_reg;
    logic [CW-1:0]       c1_col_reg;
    lzce_pkg::lzce_tag_t c1_tag_reg, c2_tag_reg;
    logic [KW-1:0]       win_reg [3][3];

    logic                wr_en;
    logic [2*KW-1:0]     wr_data;
    logic                hit;

    assign wr_en   = adv && c1_valid_reg;
    assign wr_data = {rd_reg[KW-1:0], c1_class_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[c1_col_reg] <= wr_data;
        end
        if (adv && in_valid)
        begin
            rd_reg <= (wr_en && c1_col_reg == in_col) ? wr_data : mem[in_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_reg[2*KW-1:KW];
            win_reg[1][2] <= rd_reg[KW-1:0];
            win_reg[2][2] <= c1_class_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c1_valid_reg <= in_valid;
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_class_reg <= in_class;
            c1_col_reg   <= in_col;
            c1_tag_reg   <= in_tag;
            c2_tag_reg   <= c1_tag_reg;
        end
    end

    // neighbors outside the frame never count
    always_comb
    begin
        hit = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!((r == 0 && c2_tag_reg.otop) || (r == 2 && c2_tag_reg.obot) ||
                      (c == 0 && c2_tag_reg.oleft) || (c == 2 && c2_tag_reg.oright)) &&
                    win_reg[r][c] == lzce_pkg::CLS_NEG)
                begin
                    hit = 1'b1;
                end
            end
        end
    end

    assign out_valid      = c2_valid_reg && c2_tag_reg.ov;
    assign out_background = !(win_reg[1][1] == lzce_pkg::CLS_POS && hit);
    assign out_last       = c2_tag_reg.last;

endmodule
